// File: design/alpe_pkg.sv
// Shared types and constants for the addressable LED pulse encoder.
// Used by the slot sequencer and the top level; depends on nothing else.
package alpe_pkg;

    // Store depth and frame layout.
    localparam int MAX_LEDS      = 64;
    localparam int GAP_SLOTS     = 50;
    localparam int SLOTS_PER_LED = 24;
    localparam int BUFFER_SLOTS  = GAP_SLOTS + SLOTS_PER_LED * (MAX_LEDS + 1);

    // Derived widths.
    localparam int LEN_W  = $clog2(BUFFER_SLOTS + 1);
    localparam int LED_W  = $clog2(MAX_LEDS + 2);
    localparam int LED_AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CALC_W = 14;

    // Fixed field widths.
    localparam int RGB_W   = 24;
    localparam int LIMIT_W = 10;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 7;
    localparam int BIT_W   = 5;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] LED_COUNT_RST  = 7'd64;
    localparam logic [7:0]         SLOT_TICKS_RST = 8'd130;
    localparam logic [7:0]         ONE_HIGH_RST   = 8'd70;
    localparam logic [7:0]         ZERO_HIGH_RST  = 8'd35;

    // Request operation codes; the fourth code does nothing.
    localparam logic [1:0] OP_SET_COLOR = 2'd0;
    localparam logic [1:0] OP_REFRESH   = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // Last bit position within one LED.
    localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LED_COUNT  = 2'd0,
        CFG_SLOT_TICKS = 2'd1,
        CFG_ONE_HIGH   = 2'd2,
        CFG_ZERO_HIGH  = 2'd3
    } t_cfg_idx;

    // Configuration register file.
    typedef struct packed {
        logic [COUNT_W-1:0] led_count;
        logic [7:0]         slot_ticks;
        logic [7:0]         one_high;
        logic [7:0]         zero_high;
    } t_cfg;

    // What the sequencer hands to the output stage for one request.
    typedef struct packed {
        logic             active;
        logic [7:0]       tick;
        logic [BIT_W-1:0] bit_pos;
        logic             busy;
        logic             pending;
        logic             done;
    } t_slot_info;

endpackage

// File: design/alpe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; no package needed.
module alpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/alpe_seq.sv
// Frame sequencer: busy/pending flags, frame length and the slot, LED and bit counters.
// Depends on alpe_pkg.
module alpe_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [1:0]                    i_op,
    input  logic [alpe_pkg::LIMIT_W-1:0]  i_led_limit,
    input  alpe_pkg::t_cfg                i_cfg,
    output logic [alpe_pkg::LED_AW-1:0]   o_rd_addr,
    output alpe_pkg::t_slot_info          o_info
);

    logic                          r_busy, n_busy;
    logic                          r_pend, n_pend;
    logic [alpe_pkg::LEN_W-1:0]    r_plen, n_plen;
    logic [alpe_pkg::LEN_W-1:0]    r_active, n_active;
    logic [alpe_pkg::LEN_W-1:0]    r_slot, n_slot;
    logic [7:0]                    r_tick, n_tick;
    logic [alpe_pkg::LED_W-1:0]    r_led, n_led;
    logic [alpe_pkg::BIT_W-1:0]    r_bit, n_bit;

    logic                          in_gap;
    logic                          led_ok;
    logic                          tick_now;
    logic                          done;
    logic                          start;
    logic [alpe_pkg::LIMIT_W-1:0]  lim_n;
    logic [alpe_pkg::CALC_W-1:0]   led_slots;
    logic [alpe_pkg::CALC_W-1:0]   len_raw;
    logic [alpe_pkg::LEN_W-1:0]    len;
    logic [alpe_pkg::LEN_W-1:0]    slot_inc;

    // Where the current slot lies in the frame.
    assign in_gap   = r_slot < alpe_pkg::LEN_W'(alpe_pkg::GAP_SLOTS);
    assign led_ok   = r_led < alpe_pkg::LED_W'(alpe_pkg::MAX_LEDS);
    assign tick_now = (i_op == alpe_pkg::OP_TICK) && r_busy;
    assign slot_inc = r_slot + alpe_pkg::LEN_W'(1);

    // Frame length of a refresh request: the smaller of the LED limit and the LED count, capped at the buffer size.
    always_comb begin
        if (i_led_limit >= alpe_pkg::LIMIT_W'(i_cfg.led_count)) begin
            lim_n = alpe_pkg::LIMIT_W'(i_cfg.led_count);
        end else begin
            lim_n = i_led_limit;
        end
        led_slots = alpe_pkg::CALC_W'(lim_n) + alpe_pkg::CALC_W'(1);
        len_raw   = alpe_pkg::CALC_W'(alpe_pkg::GAP_SLOTS)
                  + (led_slots << 4) + (led_slots << 3);
        if (len_raw > alpe_pkg::CALC_W'(alpe_pkg::BUFFER_SLOTS)) begin
            len = alpe_pkg::LEN_W'(alpe_pkg::BUFFER_SLOTS);
        end else begin
            len = len_raw[alpe_pkg::LEN_W-1:0];
        end
    end

    // Next state for one accepted request.
    always_comb begin
        n_busy   = r_busy;
        n_pend   = r_pend;
        n_plen   = r_plen;
        n_active = r_active;
        n_slot   = r_slot;
        n_tick   = r_tick;
        n_led    = r_led;
        n_bit    = r_bit;
        done     = 1'b0;
        start    = 1'b0;
        if (i_acc) begin
            if (i_op == alpe_pkg::OP_REFRESH) begin
                n_plen = len;
                n_pend = 1'b1;
                start  = !r_busy;
            end else if (tick_now) begin
                if ({1'b0, r_tick} + 9'd1 >= {1'b0, i_cfg.slot_ticks}) begin
                    n_tick = 8'd0;
                    // Data slots step the bit and LED counters.
                    if (!in_gap) begin
                        if (r_bit == alpe_pkg::LAST_BIT) begin
                            n_bit = '0;
                            n_led = r_led + alpe_pkg::LED_W'(1);
                        end else begin
                            n_bit = r_bit + alpe_pkg::BIT_W'(1);
                        end
                    end
                    if (slot_inc >= r_active) begin
                        n_busy = 1'b0;
                        n_slot = '0;
                        done   = 1'b1;
                        start  = r_pend;
                    end else begin
                        n_slot = slot_inc;
                    end
                end else begin
                    n_tick = r_tick + 8'd1;
                end
            end
            // Launch the waiting frame.
            if (start) begin
                n_pend   = 1'b0;
                n_busy   = 1'b1;
                n_active = n_plen;
                n_slot   = '0;
                n_tick   = 8'd0;
                n_led    = '0;
                n_bit    = '0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_plen   <= '0;
            r_active <= '0;
            r_slot   <= '0;
            r_tick   <= 8'd0;
            r_led    <= '0;
            r_bit    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_pend   <= n_pend;
            r_plen   <= n_plen;
            r_active <= n_active;
            r_slot   <= n_slot;
            r_tick   <= n_tick;
            r_led    <= n_led;
            r_bit    <= n_bit;
        end
    end

    // Color fetch address and per-request information for the output stage.
    assign o_rd_addr      = alpe_pkg::LED_AW'(r_led);
    assign o_info.active  = tick_now && !in_gap && led_ok;
    assign o_info.tick    = r_tick;
    assign o_info.bit_pos = r_bit;
    assign o_info.busy    = n_busy;
    assign o_info.pending = n_pend;
    assign o_info.done    = done;

`ifndef ASSERT_OFF
    // The bit counter never leaves one LED's 24 positions.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= alpe_pkg::LAST_BIT)
        else $error("bit counter out of range");

    // A running frame is always inside its length.
    a_slot_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_slot < r_active))
        else $error("slot index beyond frame length");

    // The slot counter rests at zero between frames.
    a_slot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_slot == '0))
        else $error("slot index not cleared while idle");
`endif

endmodule

// File: design/addressable_led_pulse_encoder_core.sv
// Addressable LED pulse encoder: top level with request/result channels and config.
// Depends on alpe_pkg, alpe_ram and alpe_seq.
//
// The block takes one request in every clock cycle and returns its result in the
// cycle after it is accepted; the output register stalls the input only when
// a result is waiting and the output side is not ready. Colors live in a
// 64-entry RAM with a registered read: a tick request fetches the color of
// the LED it is sending in the cycle it is accepted, and the line level is
// decoded from the read data in the output stage. Per-entry valid bits make
// unwritten LEDs read as black right after reset, so no clearing pass is
// needed. Configuration writes take effect on the next clock edge.
module addressable_led_pulse_encoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    // Request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [alpe_pkg::INDEX_W-1:0]  i_led_index,
    input  logic [alpe_pkg::RGB_W-1:0]    i_rgb_value,
    input  logic [alpe_pkg::LIMIT_W-1:0]  i_led_limit,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_line_level,
    output logic                          o_busy_res,
    output logic                          o_pending,
    output logic                          o_frame_done
);

    alpe_pkg::t_cfg                 r_cfg;
    alpe_pkg::t_slot_info           info;
    alpe_pkg::t_slot_info           r_s1;
    logic                           r_out_vld;
    logic                           r_s1_cv;
    logic [alpe_pkg::MAX_LEDS-1:0]  r_vld_bits;

    logic                           acc;
    logic                           idx_ok;
    logic                           wr_en;
    logic                           rd_en;
    logic [alpe_pkg::LED_AW-1:0]    wr_addr;
    logic [alpe_pkg::LED_AW-1:0]    rd_addr;
    logic [alpe_pkg::RGB_W-1:0]     rd_data;
    logic [alpe_pkg::RGB_W-1:0]     color;
    logic [alpe_pkg::BIT_W-1:0]     shift;
    logic [7:0]                     high;

    // Handshake: the output register frees up when its result is taken.
    assign o_in_ready = !r_out_vld || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count  <= alpe_pkg::LED_COUNT_RST;
            r_cfg.slot_ticks <= alpe_pkg::SLOT_TICKS_RST;
            r_cfg.one_high   <= alpe_pkg::ONE_HIGH_RST;
            r_cfg.zero_high  <= alpe_pkg::ZERO_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (alpe_pkg::t_cfg_idx'(i_cfg_index))
                alpe_pkg::CFG_LED_COUNT:  r_cfg.led_count  <= i_cfg_data[alpe_pkg::COUNT_W-1:0];
                alpe_pkg::CFG_SLOT_TICKS: r_cfg.slot_ticks <= i_cfg_data;
                alpe_pkg::CFG_ONE_HIGH:   r_cfg.one_high   <= i_cfg_data;
                alpe_pkg::CFG_ZERO_HIGH:  r_cfg.zero_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame sequencer.
    alpe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_op        (i_operation),
        .i_led_limit (i_led_limit),
        .i_cfg       (r_cfg),
        .o_rd_addr   (rd_addr),
        .o_info      (info)
    );

    // Color store writes and reads.
    assign idx_ok  = {3'b0, i_led_index} < 11'(alpe_pkg::MAX_LEDS);
    assign wr_en   = acc && (i_operation == alpe_pkg::OP_SET_COLOR) && idx_ok;
    assign wr_addr = alpe_pkg::LED_AW'(i_led_index);
    assign rd_en   = acc && info.active;

    alpe_ram #(
        .WIDTH (alpe_pkg::RGB_W),
        .DEPTH (alpe_pkg::MAX_LEDS)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rgb_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Valid bits: an entry never written reads as black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
        end else if (wr_en) begin
            r_vld_bits[wr_addr] <= 1'b1;
        end
    end

    // Output stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (acc) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_cv <= r_vld_bits[rd_addr];
        end
        if (acc) begin
            r_s1 <= info;
        end
    end

    // Pick the color bit: green first, then red, then blue, MSB first.
    always_comb begin
        color = r_s1_cv ? rd_data : '0;
        unique case (r_s1.bit_pos[4:3])
            2'd0:    shift = 5'd8 + {2'b0, ~r_s1.bit_pos[2:0]};
            2'd1:    shift = 5'd16 + {2'b0, ~r_s1.bit_pos[2:0]};
            default: shift = {2'b0, ~r_s1.bit_pos[2:0]};
        endcase
        high = color[shift] ? r_cfg.one_high : r_cfg.zero_high;
    end

    assign o_out_valid  = r_out_vld;
    assign o_line_level = r_s1.active && (r_s1.tick < high);
    assign o_busy_res   = r_s1.busy;
    assign o_pending    = r_s1.pending;
    assign o_frame_done = r_s1.done;

`ifndef ASSERT_OFF
    // A request can only wait behind a frame in progress.
    a_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pending) |-> o_busy_res)
        else $error("pending without a frame in progress");

    // A waiting request starts as soon as a frame ends.
    a_done_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> !o_pending)
        else $error("pending request not started at frame end");

    // A driven line that leaves the block idle must have ended the frame.
    a_level_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_level && !o_busy_res) |-> o_frame_done)
        else $error("line driven while idle");
`endif

endmodule
